### design/greedy_box_suppression_macros.svh
// Assertion macros used by the checker file.
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define GNMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GNMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gnms_pkg.sv
package gnms_pkg;

    localparam int COORD_BITS  = 12;
    localparam int SCORE_BITS  = 16;
    localparam int MAX_BOXES   = 64;
    localparam int LIMIT_BITS  = 8;
    localparam int AREA_BITS   = 2 * COORD_BITS;
    localparam int INTER_BITS  = 2 * COORD_BITS + 2;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd128;

    // register index, taken from paddr[2]
    localparam logic REG_OVERLAP_LIMIT = 1'b0;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
        logic [SCORE_BITS-1:0] box_score;
        logic                  box_present;
        logic                  last_box;
    } cand_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] kept_x;
        logic [COORD_BITS-1:0] kept_y;
        logic [COORD_BITS-1:0] kept_width;
        logic [COORD_BITS-1:0] kept_height;
        logic [SCORE_BITS-1:0] kept_score;
        logic                  kept_present;
        logic                  overflowed;
        logic                  last_kept;
    } kept_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
    } entry_t;

endpackage

### design/gnms_ram.sv
module gnms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/greedy_box_suppression.sv
// Greedy box suppression by overlap ratio, box list held in one RAM in score order.
// Load: one box per transfer; into an empty list it is written directly, else the
//   insertion shifts one RAM entry per cycle through the single write port.
// Run end: for each kept box the pairwise test against every later box issues
//   one RAM read per cycle into a 4-stage compare pipeline.
// Reset clears count, flags and marks and sets the threshold to 128; RAM contents stay unknown.
module greedy_box_suppression #(
    parameter int MAX_BOXES = gnms_pkg::MAX_BOXES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cand_valid,
    output logic                             cand_stall,
    input  gnms_pkg::cand_t                  cand,
    output logic                             kept_valid,
    input  logic                             kept_stall,
    output gnms_pkg::kept_t                  kept,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gnms_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [gnms_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [gnms_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int C  = gnms_pkg::COORD_BITS;
    localparam int IB = gnms_pkg::INTER_BITS;
    localparam int LB = gnms_pkg::LIMIT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_CMP, ST_INS_WR, ST_START, ST_SCAN_RD, ST_SCAN_LD,
        ST_KEEP, ST_INNER, ST_DRAIN, ST_FLUSH, ST_EMPTY
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   count_reg;
    logic                            ovf_reg;
    logic [MAX_BOXES-1:0]            marks_reg;
    logic [LB-1:0]                   limit_reg;
    logic [AW-1:0]                   pos_reg;
    gnms_pkg::entry_t                new_reg;
    logic                            last_reg;
    logic [CW-1:0]                   i_reg;
    logic [CW-1:0]                   j_reg;
    gnms_pkg::entry_t                ref_reg;
    logic [gnms_pkg::AREA_BITS-1:0]  ref_area_reg;
    gnms_pkg::entry_t                pend_reg;
    logic                            pend_valid_reg;
    logic                            kept_valid_reg;
    gnms_pkg::kept_t                 kept_reg;

    // compare pipeline
    logic                            rd_v_reg;
    logic [AW-1:0]                   rd_j_reg;
    logic                            s2_v_reg, s3_v_reg, s4_v_reg;
    logic [AW-1:0]                   s2_j_reg, s3_j_reg, s4_j_reg;
    logic                            s2_ok_reg, s3_ok_reg, s4_ok_reg;
    logic [C:0]                      s2_dx_reg, s2_dy_reg;
    logic [gnms_pkg::AREA_BITS-1:0]  s2_aq_reg, s3_aq_reg;
    logic [IB-1:0]                   s3_inter_reg, s4_inter_reg, s4_uni_reg;

    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr, mem_raddr;
    gnms_pkg::entry_t                mem_wdata;
    logic [$bits(gnms_pkg::entry_t)-1:0] mem_rdata;
    gnms_pkg::entry_t                rd_entry;
    gnms_pkg::entry_t                cand_entry;

    logic                            cand_fire, out_free, full, pipe_empty, shift;
    logic                            cfg_wr;
    logic [C:0]                      pr, qr, pb, qb, rgt, bot, lft, top;
    logic [IB+LB-1:0]                lhs, rhs;
    logic                            hit;
    state_t                          after_ins;
    logic                            out_load;
    gnms_pkg::kept_t                 out_data;

    function automatic gnms_pkg::kept_t to_kept(gnms_pkg::entry_t e, logic ovf, logic last);
        gnms_pkg::kept_t k;
        k.kept_x       = e.x;
        k.kept_y       = e.y;
        k.kept_width   = e.w;
        k.kept_height  = e.h;
        k.kept_score   = e.score;
        k.kept_present = 1'b1;
        k.overflowed   = ovf;
        k.last_kept    = last;
        return k;
    endfunction

    gnms_ram #(
        .WIDTH ($bits(gnms_pkg::entry_t)),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_entry   = gnms_pkg::entry_t'(mem_rdata);
    assign cand_entry = '{x: cand.box_x, y: cand.box_y, w: cand.box_width,
                          h: cand.box_height, score: cand.box_score};

    assign cand_stall = (state_reg != ST_IDLE);
    assign cand_fire  = cand_valid && !cand_stall;
    assign kept_valid = kept_valid_reg;
    assign kept       = kept_reg;
    assign out_free   = !kept_valid_reg || !kept_stall;
    assign full       = (count_reg == CW'(MAX_BOXES));
    assign pipe_empty = !rd_v_reg && !s2_v_reg && !s3_v_reg && !s4_v_reg;
    assign shift      = (rd_entry.score < new_reg.score);
    assign after_ins  = last_reg ? ST_START : ST_IDLE;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == gnms_pkg::REG_OVERLAP_LIMIT)
                    ? gnms_pkg::PDATA_BITS'(limit_reg) : '0;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = new_reg;
        mem_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cand_fire && cand.box_present && !full)
                begin
                    if (count_reg == '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = cand_entry;
                    end
                    else
                    begin
                        mem_raddr = AW'(count_reg - 1'b1);
                    end
                end
            end
            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (shift)
                begin
                    mem_wdata = rd_entry;
                    mem_raddr = pos_reg - AW'(2);
                end
            end
            ST_INS_WR:  mem_we = 1'b1;
            ST_SCAN_RD: mem_raddr = i_reg[AW-1:0];
            ST_INNER:   mem_raddr = j_reg[AW-1:0];
            default:    mem_we = 1'b0;
        endcase
    end

    // result register load: previous kept box, final kept box or empty marker
    always_comb
    begin
        out_load = 1'b0;
        out_data = to_kept(pend_reg, ovf_reg, 1'b0);
        case (state_reg)
            ST_KEEP:
            begin
                out_load = pend_valid_reg && out_free;
            end
            ST_FLUSH:
            begin
                out_load = out_free;
                out_data = to_kept(pend_reg, ovf_reg, 1'b1);
            end
            ST_EMPTY:
            begin
                out_load            = out_free;
                out_data            = '0;
                out_data.overflowed = ovf_reg;
                out_data.last_kept  = 1'b1;
            end
            default: out_load = 1'b0;
        endcase
    end

    // overlap geometry of reference box p and streamed box q
    always_comb
    begin
        pr  = {1'b0, ref_reg.x} + {1'b0, ref_reg.w};
        qr  = {1'b0, rd_entry.x} + {1'b0, rd_entry.w};
        pb  = {1'b0, ref_reg.y} + {1'b0, ref_reg.h};
        qb  = {1'b0, rd_entry.y} + {1'b0, rd_entry.h};
        rgt = (pr < qr) ? pr : qr;
        bot = (pb < qb) ? pb : qb;
        lft = (ref_reg.x > rd_entry.x) ? {1'b0, ref_reg.x} : {1'b0, rd_entry.x};
        top = (ref_reg.y > rd_entry.y) ? {1'b0, ref_reg.y} : {1'b0, rd_entry.y};
    end

    assign lhs = {s4_inter_reg, {LB{1'b0}}};
    assign rhs = (IB+LB)'(limit_reg) * (IB+LB)'(s4_uni_reg);
    assign hit = s4_ok_reg && (lhs > rhs);

    always_ff @(posedge clk)
    begin
        s2_j_reg  <= rd_j_reg;
        s2_ok_reg <= (rgt >= lft) && (bot >= top);
        s2_dx_reg <= rgt - lft;
        s2_dy_reg <= bot - top;
        s2_aq_reg <= gnms_pkg::AREA_BITS'(rd_entry.w) * gnms_pkg::AREA_BITS'(rd_entry.h);
        s3_j_reg     <= s2_j_reg;
        s3_ok_reg    <= s2_ok_reg;
        s3_inter_reg <= IB'(s2_dx_reg) * IB'(s2_dy_reg);
        s3_aq_reg    <= s2_aq_reg;
        s4_j_reg     <= s3_j_reg;
        s4_ok_reg    <= s3_ok_reg;
        s4_inter_reg <= s3_inter_reg;
        s4_uni_reg   <= IB'(ref_area_reg) + IB'(s3_aq_reg) - s3_inter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            marks_reg      <= '0;
            limit_reg      <= gnms_pkg::LIMIT_RESET;
            pos_reg        <= '0;
            new_reg        <= '0;
            last_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            ref_reg        <= '0;
            ref_area_reg   <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            kept_valid_reg <= 1'b0;
            kept_reg       <= '0;
            rd_v_reg       <= 1'b0;
            rd_j_reg       <= '0;
            s2_v_reg       <= 1'b0;
            s3_v_reg       <= 1'b0;
            s4_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == gnms_pkg::REG_OVERLAP_LIMIT)
            begin
                limit_reg <= pwdata[LB-1:0];
            end
            if (out_load)
            begin
                kept_reg       <= out_data;
                kept_valid_reg <= 1'b1;
            end
            else if (kept_valid_reg && !kept_stall)
            begin
                kept_valid_reg <= 1'b0;
            end

            rd_v_reg <= (state_reg == ST_INNER) && (j_reg != count_reg);
            s2_v_reg <= rd_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (s4_v_reg && hit)
            begin
                marks_reg[s4_j_reg] <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cand_fire)
                    begin
                        last_reg <= cand.last_box;
                        new_reg  <= cand_entry;
                        if (cand.box_present && !full)
                        begin
                            if (count_reg == '0)
                            begin
                                count_reg <= count_reg + 1'b1;
                                state_reg <= cand.last_box ? ST_START : ST_IDLE;
                            end
                            else
                            begin
                                pos_reg   <= count_reg[AW-1:0];
                                state_reg <= ST_INS_CMP;
                            end
                        end
                        else
                        begin
                            if (cand.box_present)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            state_reg <= cand.last_box ? ST_START : ST_IDLE;
                        end
                    end
                end
                ST_INS_CMP:
                begin
                    if (shift)
                    begin
                        pos_reg <= pos_reg - 1'b1;
                        if (pos_reg == AW'(1))
                        begin
                            state_reg <= ST_INS_WR;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= after_ins;
                    end
                end
                ST_INS_WR:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= after_ins;
                end
                ST_START:
                begin
                    i_reg     <= '0;
                    state_reg <= (count_reg == '0) ? ST_EMPTY : ST_SCAN_RD;
                end
                ST_SCAN_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else if (marks_reg[i_reg[AW-1:0]])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_LD;
                    end
                end
                ST_SCAN_LD:
                begin
                    ref_reg      <= rd_entry;
                    ref_area_reg <= gnms_pkg::AREA_BITS'(rd_entry.w)
                                    * gnms_pkg::AREA_BITS'(rd_entry.h);
                    state_reg    <= ST_KEEP;
                end
                ST_KEEP:
                begin
                    // previous kept box goes out once a later one is known
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_reg       <= ref_reg;
                        pend_valid_reg <= 1'b1;
                        j_reg          <= i_reg + 1'b1;
                        state_reg      <= ST_INNER;
                    end
                end
                ST_INNER:
                begin
                    if (j_reg == count_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_j_reg <= j_reg[AW-1:0];
                        j_reg    <= j_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        marks_reg      <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        ovf_reg   <= 1'b0;
                        marks_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### design/gnms_checker.sv
`include "greedy_box_suppression_macros.svh"

module gnms_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cand_valid,
    input logic                             cand_stall,
    input gnms_pkg::cand_t                  cand,
    input logic                             kept_valid,
    input logic                             kept_stall,
    input gnms_pkg::kept_t                  kept,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [gnms_pkg::PADDR_BITS-1:0]  paddr,
    input logic [gnms_pkg::PDATA_BITS-1:0]  pwdata,
    input logic [gnms_pkg::PDATA_BITS-1:0]  prdata,
    input logic                             pready
);

    `GNMS_ASSERT(a_out_hold, kept_valid && kept_stall |=> kept_valid && $stable(kept), "stalled result changed")
    `GNMS_ASSERT(a_marker_last, kept_valid && !kept.kept_present |-> kept.last_kept, "empty marker must end run")
    `GNMS_ASSERT(a_busy_mid_run, kept_valid && !kept.last_kept |-> cand_stall, "input taken during a run")
    `GNMS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !kept_valid, "result valid in reset")

endmodule

bind greedy_box_suppression gnms_checker u_gnms_checker (.*);

### verif/greedy_box_suppression_tb.sv
module greedy_box_suppression_tb;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cand_valid;
    logic cand_stall;
    gnms_pkg::cand_t cand;
    logic kept_valid;
    logic kept_stall;
    gnms_pkg::kept_t kept;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gnms_pkg::PADDR_BITS-1:0] paddr;
    logic [gnms_pkg::PDATA_BITS-1:0] pwdata;
    logic [gnms_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    greedy_box_suppression i_dut (
        .clk(clk), .rst_n(rst_n),
        .cand_valid(cand_valid), .cand_stall(cand_stall), .cand(cand),
        .kept_valid(kept_valid), .kept_stall(kept_stall), .kept(kept),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    gnms_pkg::entry_t sorted_boxes [gnms_pkg::MAX_BOXES];
    int unsigned held_count;
    bit dropped_any;
    bit [gnms_pkg::LIMIT_BITS-1:0] limit_q8;

    gnms_pkg::cand_t pending_cands [$];
    gnms_pkg::kept_t kept_expected [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned hold_cycles;
    bit hold_request;
    bit send_pause;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic void queue_cand(gnms_pkg::cand_t c);
        pending_cands = {pending_cands, c};
    endfunction

    function automatic void expect_kept(gnms_pkg::kept_t k);
        kept_expected = {kept_expected, k};
    endfunction

    function automatic bit too_close(gnms_pkg::entry_t p, gnms_pkg::entry_t q);
        logic [63:0] lft, tp, rgt, bot, inter, uni;
        lft = (p.x > q.x) ? 64'(p.x) : 64'(q.x);
        tp = (p.y > q.y) ? 64'(p.y) : 64'(q.y);
        rgt = ((64'(p.x) + p.w) < (64'(q.x) + q.w)) ? 64'(p.x) + p.w : 64'(q.x) + q.w;
        bot = ((64'(p.y) + p.h) < (64'(q.y) + q.h)) ? 64'(p.y) + p.h : 64'(q.y) + q.h;
        if (rgt < lft || bot < tp)
            return 1'b0;
        inter = (rgt - lft) * (bot - tp);
        uni = 64'(p.w) * p.h + 64'(q.w) * q.h - inter;
        return inter * 256 > 64'(limit_q8) * uni;
    endfunction

    task automatic predict_kept(gnms_pkg::cand_t c);
        gnms_pkg::entry_t e;
        int unsigned pos;
        bit gone [gnms_pkg::MAX_BOXES];
        gnms_pkg::kept_t r;
        if (c.box_present)
        begin
            if (held_count < gnms_pkg::MAX_BOXES)
            begin
                e = '{c.box_x, c.box_y, c.box_width, c.box_height, c.box_score};
                pos = held_count;
                while (pos > 0 && sorted_boxes[pos-1].score < e.score)
                begin
                    sorted_boxes[pos] = sorted_boxes[pos-1];
                    pos--;
                end
                sorted_boxes[pos] = e;
                held_count++;
            end
            else
                dropped_any = 1'b1;
        end
        if (!c.last_box)
            return;
        if (held_count == 0)
        begin
            r = '0;
            r.overflowed = dropped_any;
            r.last_kept = 1'b1;
            expect_kept(r);
        end
        else
        begin
            foreach (gone[k]) gone[k] = 1'b0;
            for (int i = 0; i < held_count; i++)
            begin
                if (gone[i])
                    continue;
                for (int j = i + 1; j < held_count; j++)
                    if (!gone[j] && too_close(sorted_boxes[i], sorted_boxes[j]))
                        gone[j] = 1'b1;
                r.kept_x = sorted_boxes[i].x;
                r.kept_y = sorted_boxes[i].y;
                r.kept_width = sorted_boxes[i].w;
                r.kept_height = sorted_boxes[i].h;
                r.kept_score = sorted_boxes[i].score;
                r.kept_present = 1'b1;
                r.overflowed = dropped_any;
                r.last_kept = 1'b0;
                expect_kept(r);
            end
            kept_expected[kept_expected.size()-1].last_kept = 1'b1;
        end
        held_count = 0;
        dropped_any = 1'b0;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid <= 1'b0;
            cand <= '0;
            send_wait <= 0;
        end
        else if (cand_valid && !cand_stall)
        begin
            predict_kept(cand);
            if (pending_cands.size() > 0 && $urandom_range(0, 7) == 0 && !send_pause)
            begin
                cand <= pending_cands.pop_front();
            end
            else
            begin
                cand_valid <= 1'b0;
                send_wait <= $urandom_range(0, 7);
            end
        end
        else if (!cand_valid)
        begin
            if (send_wait > 0)
                send_wait <= send_wait - 1;
            else if (pending_cands.size() > 0 && !send_pause)
            begin
                cand <= pending_cands.pop_front();
                cand_valid <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_request && hold_cycles == 0)
            hold_cycles <= 3000;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // receiver stall and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_stall <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (kept_valid && !kept_stall)
            begin
                if (kept_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", kept);
                end
                else if (kept !== kept_expected[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", kept_expected[0], kept);
                    void'(kept_expected.pop_front());
                end
                else
                    void'(kept_expected.pop_front());
            end
            if (hold_cycles != 0)
                kept_stall <= 1'b1;
            else if (kept_valid && !kept_stall)
            begin
                recv_wait <= $urandom_range(0, 7);
                kept_stall <= ($urandom_range(0, 1) == 1);
            end
            else if (recv_wait > 0)
                recv_wait <= recv_wait - 1;
            else
                kept_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic gnms_pkg::cand_t rand_box(bit last, int crowd);
        gnms_pkg::cand_t c;
        c.box_x = (crowd > 0) ? 12'($urandom_range(0, crowd)) : 12'($urandom);
        c.box_y = (crowd > 0) ? 12'($urandom_range(0, crowd)) : 12'($urandom);
        c.box_width = (crowd > 0) ? 12'($urandom_range(0, crowd)) : 12'($urandom);
        c.box_height = (crowd > 0) ? 12'($urandom_range(0, crowd)) : 12'($urandom);
        c.box_score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        c.box_present = 1'b1;
        c.last_box = last;
        return c;
    endfunction

    function automatic gnms_pkg::cand_t mk(int x, int y, int w, int h, int s, bit p, bit l);
        return '{12'(x), 12'(y), 12'(w), 12'(h), 16'(s), p, l};
    endfunction

    task automatic cfg_write(logic [gnms_pkg::LIMIT_BITS-1:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {gnms_pkg::REG_OVERLAP_LIMIT, 2'b00};
        pwdata <= 32'(v) | ($urandom & 32'hFFFF_FF00);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        limit_q8 = v;
    endtask

    task automatic drain_all();
        while (pending_cands.size() > 0 || cand_valid || kept_expected.size() > 0)
            @(posedge clk);
        repeat (10000) @(posedge clk);
    endtask

    initial
    begin
        int n;
        bit [gnms_pkg::LIMIT_BITS-1:0] limits [5] = '{8'd128, 8'd0, 8'd255, 8'd64, 8'd200};
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        held_count = 0; dropped_any = 1'b0; limit_q8 = gnms_pkg::LIMIT_RESET;
        mismatches = 0; cycle_count = 0; hold_request = 1'b0; send_pause = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty set, bare item, extremes, ties, zero area
        queue_cand(mk(0, 0, 0, 0, 0, 0, 1));
        queue_cand(mk(5, 5, 5, 5, 5, 0, 0));
        queue_cand(mk(4095, 4095, 4095, 4095, 65535, 1, 1));
        queue_cand(mk(10, 10, 0, 0, 7, 1, 0));
        queue_cand(mk(10, 10, 0, 0, 7, 1, 0));
        queue_cand(mk(0, 0, 100, 100, 7, 1, 0));
        queue_cand(mk(1, 1, 100, 100, 9, 1, 0));
        queue_cand(mk(300, 0, 50, 50, 65535, 1, 0));
        queue_cand(mk(4000, 4000, 4095, 4095, 0, 1, 0));
        queue_cand(mk(0, 0, 0, 0, 0, 0, 1));
        drain_all();

        // overflow: 66 boxes, the last two dropped
        for (int i = 0; i < 66; i++)
            queue_cand(rand_box(i == 65, 4095));
        queue_cand(mk(0, 0, 0, 0, 0, 0, 0));
        queue_cand(mk(0, 0, 0, 0, 0, 1, 1));
        hold_request = 1'b1;
        wait (hold_cycles != 0);
        hold_request = 1'b0;
        drain_all();

        for (int ph = 0; ph < 5; ph++)
        begin
            cfg_write(limits[ph]);
            for (int s = 0; s < 5; s++)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    queue_cand(rand_box(i == n - 1, (s % 2) ? 200 : 0));
                if ($urandom_range(0, 5) == 0)
                    queue_cand(mk(0, 0, 0, 0, 0, 0, 1'($urandom_range(0, 1))));
            end
            if (ph == 2)
            begin
                while (pending_cands.size() > 0 || cand_valid) @(posedge clk);
                send_pause = 1'b1;
                while (kept_expected.size() > 0) @(posedge clk);
                send_pause = 1'b0;
            end
            drain_all();
        end

        if (mismatches == 0 && kept_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
